// File: rtl/bounded_list_insert_delete_sort_assert.svh
// Assertion macros used by the list engine top level.
`ifndef BOUNDED_LIST_INSERT_DELETE_SORT_ASSERT_SVH
`define BOUNDED_LIST_INSERT_DELETE_SORT_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define BLIDS_ASSERT_ALWAYS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("list engine check failed");

// Check that an antecedent implies a consequent in the same cycle.
`define BLIDS_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("list engine check failed");

// Check that an antecedent implies a consequent in the following cycle.
`define BLIDS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("list engine check failed");

`endif

// File: rtl/blids_pkg.sv
// Package: types, codes and constants of the bounded list engine.
`timescale 1ns / 1ps
`default_nettype none
package blids_pkg;

	localparam int DEPTH_DEF      = 32;
	localparam int DATA_WIDTH_DEF = 32;
	// index width covering every supported depth and count
	localparam int IDX_W          = 11;
	localparam int KIND_W         = 3;
	localparam int POS_W          = 6;
	localparam int CNT_W          = 6;
	localparam int VAL_W          = 32;

	typedef enum logic [KIND_W-1:0] {
		K_INSERT_AT    = 3'd0,
		K_APPEND       = 3'd1,
		K_DELETE_AT    = 3'd2,
		K_DELETE_FIRST = 3'd3,
		K_DELETE_ALL   = 3'd4,
		K_SORT         = 3'd5,
		K_READ         = 3'd6
	} kind_t;

	typedef enum logic [2:0] {
		C_HOLD,
		C_INSERT,
		C_WRITE,
		C_DELETE,
		C_ROTATE,
		C_SORT
	} cell_op_t;

	// broadcast command to every cell of the row
	typedef struct packed {
		cell_op_t         op;
		logic [IDX_W-1:0] sel;
		logic             phase;
		logic             keep;
	} cell_ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROT,
		ST_SORT,
		ST_RES
	} state_t;

endpackage
`default_nettype wire

// File: rtl/blids_if.sv
// Interfaces: request and response channels of the list engine.
`timescale 1ns / 1ps
`default_nettype none
interface blids_req_if;
	logic                              valid;
	logic                              ready;
	logic [blids_pkg::KIND_W-1:0]      kind;
	logic [blids_pkg::POS_W-1:0]       position;
	logic signed [blids_pkg::VAL_W-1:0] value;

	modport source (output valid, kind, position, value, input ready);
	modport sink   (input valid, kind, position, value, output ready);
endinterface

interface blids_rsp_if;
	logic                              valid;
	logic                              ready;
	logic                              status;
	logic [blids_pkg::CNT_W-1:0]       removed_count;
	logic [blids_pkg::CNT_W-1:0]       entry_count;
	logic signed [blids_pkg::VAL_W-1:0] read_value;

	modport source (output valid, status, removed_count, entry_count, read_value, input ready);
	modport sink   (input valid, status, removed_count, entry_count, read_value, output ready);
endinterface
`default_nettype wire

// File: rtl/blids_cell.sv
// One list cell: holds a single entry and trades it with its neighbours.
`timescale 1ns / 1ps
`default_nettype none
module blids_cell #(
	parameter int DEPTH      = blids_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = blids_pkg::DATA_WIDTH_DEF,
	parameter int INDEX      = 0
) (
	input  wire logic                         clk,
	input  wire blids_pkg::cell_ctl_t         ctl,
	input  wire logic signed [DATA_WIDTH-1:0] value,
	input  wire logic signed [DATA_WIDTH-1:0] left,
	input  wire logic signed [DATA_WIDTH-1:0] right,
	input  wire logic signed [DATA_WIDTH-1:0] head,
	output logic signed [DATA_WIDTH-1:0]      data
);

	localparam logic [blids_pkg::IDX_W:0] I0 = (blids_pkg::IDX_W+1)'(INDEX);
	localparam logic [blids_pkg::IDX_W:0] I1 = (blids_pkg::IDX_W+1)'(INDEX + 1);
	localparam bit IS_LAST  = (INDEX == DEPTH - 1);
	localparam bit IS_FIRST = (INDEX == 0);

	logic signed [DATA_WIDTH-1:0] data_q;
	logic signed [DATA_WIDTH-1:0] data_d;
	logic [blids_pkg::IDX_W:0]    sel;
	logic                         pair_left;
	logic                         pair_right;

	assign sel        = {1'b0, ctl.sel};
	assign pair_left  = (I0[0] == ctl.phase) && (I1 < sel);
	assign pair_right = (I0[0] != ctl.phase) && !IS_FIRST && (I0 < sel);

	// pick the next entry from the broadcast command
	always_comb begin
		data_d = data_q;
		case (ctl.op)
			blids_pkg::C_INSERT: begin
				if (I0 == sel)
					data_d = value;
				else if (I0 > sel)
					data_d = left;
			end
			blids_pkg::C_WRITE: begin
				if (I0 == sel)
					data_d = value;
			end
			blids_pkg::C_DELETE: begin
				if (I0 >= sel && !IS_LAST)
					data_d = right;
			end
			blids_pkg::C_ROTATE: begin
				if (I1 < sel)
					data_d = right;
				else if (I1 == sel && ctl.keep)
					data_d = head;
			end
			blids_pkg::C_SORT: begin
				if (pair_left && data_q > right)
					data_d = right;
				else if (pair_right && left > data_q)
					data_d = left;
			end
			default: data_d = data_q;
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data = data_q;

endmodule
`default_nettype wire

// File: rtl/bounded_list_insert_delete_sort.sv
// Top level: bounded signed list engine built on a row of cells.
//
//  channel | dir | fields
//  req     | in  | kind, position, value
//  rsp     | out | status, removed_count, entry_count, read_value
//
// Insert, append, delete at position and unknown kinds go from idle straight to
// the result state. Match deletes and read rotate the list once through the cell
// row, head back to tail. Sort runs odd-even transposition between neighbouring
// cells. arst_n clears the count and the control; entries need no reset. A stalled
// rsp holds the result; a new transaction is taken while the previous result
// waits in the output register.
`timescale 1ns / 1ps
`default_nettype none
`include "bounded_list_insert_delete_sort_assert.svh"
module bounded_list_insert_delete_sort #(
	parameter int DEPTH      = blids_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = blids_pkg::DATA_WIDTH_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	blids_req_if.sink     req,
	blids_rsp_if.source   rsp
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = blids_pkg::IDX_W;
	localparam logic [IW-1:0] DEPTH_I = IW'(DEPTH);
	localparam logic [IW-1:0] LAST_I  = IW'(DEPTH - 1);

	blids_pkg::state_t    state_q, state_d;
	blids_pkg::cell_ctl_t ctl;

	logic [CW-1:0]                 cnt_q;
	logic [CW-1:0]                 step_q;
	logic [CW-1:0]                 len_q;
	logic [CW-1:0]                 rem_q;
	logic                          found_q;
	logic                          phase_q;
	logic [blids_pkg::KIND_W-1:0]  kind_q;
	logic [blids_pkg::POS_W-1:0]   pos_q;
	logic signed [DATA_WIDTH-1:0]  val_q;
	logic signed [blids_pkg::VAL_W-1:0] rd_q;

	logic                          res_status_q;
	logic [CW-1:0]                 res_rem_q;
	logic [CW-1:0]                 res_cnt_q;
	logic signed [blids_pkg::VAL_W-1:0] res_rd_q;

	logic                          out_v_q;
	logic                          out_status_q;
	logic [blids_pkg::CNT_W-1:0]   out_rem_q;
	logic [blids_pkg::CNT_W-1:0]   out_cnt_q;
	logic signed [blids_pkg::VAL_W-1:0] out_rd_q;

	logic signed [DATA_WIDTH-1:0] cell_data [DEPTH];
	logic signed [DATA_WIDTH-1:0] val_w;
	logic signed [DATA_WIDTH-1:0] cell_val;
	logic signed [DATA_WIDTH-1:0] head;

	logic          acc;
	logic          full;
	logic [IW-1:0] pos_e;
	logic [IW-1:0] cnt_e;
	logic          imm_status;
	logic [CW-1:0] imm_rem;
	logic [CW-1:0] imm_cnt;
	logic          rot_keep;
	logic          rot_match;
	logic          out_free;

	assign acc      = req.valid && req.ready;
	assign full     = (cnt_q == CW'(DEPTH));
	assign pos_e    = IW'(req.position);
	assign cnt_e    = IW'(cnt_q);
	assign val_w    = DATA_WIDTH'(req.value);
	assign head     = cell_data[0];
	assign out_free = !out_v_q || rsp.ready;
	assign rot_match = (head == val_q);

	// decide whether the head survives this rotation step
	always_comb begin
		case (blids_pkg::kind_t'(kind_q))
			blids_pkg::K_DELETE_FIRST: rot_keep = !(rot_match && !found_q);
			blids_pkg::K_DELETE_ALL:   rot_keep = !rot_match;
			default:                   rot_keep = 1'b1;
		endcase
	end

	// drive the cell row, the immediate result and the next state
	always_comb begin
		state_d    = state_q;
		ctl        = '{op: blids_pkg::C_HOLD, sel: '0, phase: 1'b0, keep: 1'b0};
		cell_val   = val_w;
		imm_status = 1'b0;
		imm_rem    = '0;
		imm_cnt    = cnt_q;
		case (state_q)
			blids_pkg::ST_IDLE: begin
				if (acc) begin
					state_d = blids_pkg::ST_RES;
					case (blids_pkg::kind_t'(req.kind))
						blids_pkg::K_INSERT_AT: begin
							if (pos_e > cnt_e) begin
								imm_status = 1'b1;
							end else if (full && pos_e >= DEPTH_I) begin
								imm_rem = CW'(1);
							end else begin
								ctl.op  = blids_pkg::C_INSERT;
								ctl.sel = pos_e;
								imm_rem = full ? CW'(1) : '0;
								imm_cnt = full ? cnt_q : cnt_q + CW'(1);
							end
						end
						blids_pkg::K_APPEND: begin
							ctl.op  = blids_pkg::C_WRITE;
							ctl.sel = full ? LAST_I : cnt_e;
							imm_rem = full ? CW'(1) : '0;
							imm_cnt = full ? cnt_q : cnt_q + CW'(1);
						end
						blids_pkg::K_DELETE_AT: begin
							if (pos_e == '0 || pos_e > cnt_e) begin
								imm_status = 1'b1;
							end else begin
								ctl.op  = blids_pkg::C_DELETE;
								ctl.sel = pos_e - IW'(1);
								imm_rem = CW'(1);
								imm_cnt = cnt_q - CW'(1);
							end
						end
						blids_pkg::K_DELETE_FIRST,
						blids_pkg::K_DELETE_ALL,
						blids_pkg::K_READ: state_d = blids_pkg::ST_ROT;
						blids_pkg::K_SORT: state_d = blids_pkg::ST_SORT;
						default: imm_status = 1'b1;
					endcase
				end
			end
			blids_pkg::ST_ROT: begin
				if (step_q != cnt_q) begin
					ctl.op   = blids_pkg::C_ROTATE;
					ctl.sel  = IW'(len_q);
					ctl.keep = rot_keep;
				end else begin
					state_d = blids_pkg::ST_RES;
				end
			end
			blids_pkg::ST_SORT: begin
				if (step_q != cnt_q) begin
					ctl.op    = blids_pkg::C_SORT;
					ctl.sel   = cnt_e;
					ctl.phase = phase_q;
				end else begin
					state_d = blids_pkg::ST_RES;
				end
			end
			blids_pkg::ST_RES: begin
				if (out_free)
					state_d = blids_pkg::ST_IDLE;
			end
			default: state_d = blids_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= blids_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// count and engine counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			step_q  <= '0;
			len_q   <= '0;
			rem_q   <= '0;
			found_q <= 1'b0;
			phase_q <= 1'b0;
		end else begin
			case (state_q)
				blids_pkg::ST_IDLE: begin
					if (acc) begin
						cnt_q   <= imm_cnt;
						step_q  <= '0;
						len_q   <= cnt_q;
						rem_q   <= '0;
						found_q <= 1'b0;
						phase_q <= 1'b0;
					end
				end
				blids_pkg::ST_ROT: begin
					if (step_q != cnt_q) begin
						step_q <= step_q + CW'(1);
						if (!rot_keep) begin
							len_q   <= len_q - CW'(1);
							rem_q   <= rem_q + CW'(1);
							found_q <= 1'b1;
						end
					end else begin
						cnt_q <= len_q;
					end
				end
				blids_pkg::ST_SORT: begin
					if (step_q != cnt_q) begin
						step_q  <= step_q + CW'(1);
						phase_q <= !phase_q;
					end
				end
				default: ;
			endcase
		end
	end

	// payload of the transaction in flight and its result
	always_ff @(posedge clk) begin
		if (acc) begin
			kind_q       <= req.kind;
			pos_q        <= req.position;
			val_q        <= val_w;
			rd_q         <= '0;
			res_status_q <= imm_status;
			res_rem_q    <= imm_rem;
			res_cnt_q    <= imm_cnt;
			res_rd_q     <= '0;
		end
		if (state_q == blids_pkg::ST_ROT) begin
			if (step_q != cnt_q) begin
				if (IW'(step_q) == IW'(pos_q))
					rd_q <= blids_pkg::VAL_W'(head);
			end else if (blids_pkg::kind_t'(kind_q) == blids_pkg::K_READ) begin
				res_status_q <= (IW'(pos_q) >= cnt_e);
				res_rem_q    <= '0;
				res_cnt_q    <= cnt_q;
				res_rd_q     <= (IW'(pos_q) >= cnt_e) ? '0 : rd_q;
			end else begin
				res_status_q <= (rem_q == '0);
				res_rem_q    <= rem_q;
				res_cnt_q    <= len_q;
				res_rd_q     <= '0;
			end
		end
		if (state_q == blids_pkg::ST_SORT && step_q == cnt_q) begin
			res_status_q <= 1'b0;
			res_rem_q    <= '0;
			res_cnt_q    <= cnt_q;
			res_rd_q     <= '0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (state_q == blids_pkg::ST_RES && out_free) begin
			out_v_q <= 1'b1;
		end else if (rsp.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == blids_pkg::ST_RES && out_free) begin
			out_status_q <= res_status_q;
			out_rem_q    <= blids_pkg::CNT_W'(res_rem_q);
			out_cnt_q    <= blids_pkg::CNT_W'(res_cnt_q);
			out_rd_q     <= res_rd_q;
		end
	end

	// row of cells
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [DATA_WIDTH-1:0] left_n;
		logic signed [DATA_WIDTH-1:0] right_n;
		if (i == 0) begin : g_first
			assign left_n = cell_data[i];
		end else begin : g_mid_l
			assign left_n = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_n = cell_data[i];
		end else begin : g_mid_r
			assign right_n = cell_data[i+1];
		end
		blids_cell #(
			.DEPTH      (DEPTH),
			.DATA_WIDTH (DATA_WIDTH),
			.INDEX      (i)
		) u_cell (
			.clk   (clk),
			.ctl   (ctl),
			.value (cell_val),
			.left  (left_n),
			.right (right_n),
			.head  (head),
			.data  (cell_data[i])
		);
	end

	assign req.ready         = (state_q == blids_pkg::ST_IDLE);
	assign rsp.valid         = out_v_q;
	assign rsp.status        = out_status_q;
	assign rsp.removed_count = out_rem_q;
	assign rsp.entry_count   = out_cnt_q;
	assign rsp.read_value    = out_rd_q;

	`BLIDS_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= CW'(DEPTH))
	`BLIDS_ASSERT_NEXT(a_busy_after_accept, acc, state_q != blids_pkg::ST_IDLE)
	`BLIDS_ASSERT_IMPL(a_rot_len, state_q == blids_pkg::ST_ROT, len_q <= cnt_q && step_q <= cnt_q)

endmodule
`default_nettype wire
